>>> hw/rtl/srld_pkg.sv
// ----------------------------------------------------------------------------
// srld_pkg
// Shared types and constants of the sensor ring line detector.
// ----------------------------------------------------------------------------
`default_nettype none

package srld_pkg;

  localparam int Sensors    = 32;
  localparam int SensorW    = 5;
  localparam int SampleBits = 12;
  localparam int ChordW     = 5;
  localparam int AngleW     = SensorW + 1;
  localparam int ExclW      = 6;
  localparam int CfgIdxW    = 1;

  localparam logic [SensorW-1:0]    HalfRing = SensorW'(Sensors / 2);
  localparam logic [SampleBits-1:0] MinStart = SampleBits'(1200);

  // request kinds
  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindFrame  = 2'd1;
  localparam logic [1:0] KindThresh = 2'd2;
  localparam logic [1:0] KindClear  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCalibrating = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgExcluded    = 1'd1;

  typedef struct packed {
    logic [1:0]            kind;
    logic [SensorW-1:0]    sensor;
    logic [SampleBits-1:0] value;
  } srld_req_t;

  typedef struct packed {
    logic               on_line;
    logic [AngleW-1:0]  line_angle;
    logic [ChordW-1:0]  chord_steps;
    logic               first_contact;
    logic [SensorW-1:0] gap_start;
    logic [SensorW-1:0] gap_end;
  } srld_res_t;

  // outcome of one walk over the detected set
  typedef struct packed {
    logic               on;
    logic [AngleW-1:0]  angle;
    logic [ChordW-1:0]  chord;
    logic [SensorW-1:0] lo;
    logic [SensorW-1:0] hi;
  } srld_walk_t;

endpackage

`default_nettype wire

>>> hw/rtl/srld_alu.sv
// ----------------------------------------------------------------------------
// srld_alu
// Shared compare and midpoint unit for sample handling.
// ----------------------------------------------------------------------------
`default_nettype none

module srld_alu (
  input  wire logic [srld_pkg::SampleBits-1:0] op_a_i,
  input  wire logic [srld_pkg::SampleBits-1:0] op_b_i,
  output logic                                 gt_o,
  output logic [srld_pkg::SampleBits-1:0]      mid_o
);

  logic [srld_pkg::SampleBits:0] sum;

  assign sum   = {1'b0, op_a_i} + {1'b0, op_b_i};
  assign gt_o  = op_a_i > op_b_i;
  assign mid_o = sum[srld_pkg::SampleBits:1];

endmodule

`default_nettype wire

>>> hw/rtl/srld_gap.sv
// ----------------------------------------------------------------------------
// srld_gap
// Widest circular pair search: offset scan with a rotating copy of the set,
// then, when a pair was found, a walk over lower indexes for the first pair at the widest offset.
// ----------------------------------------------------------------------------
`default_nettype none

module srld_gap (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [srld_pkg::Sensors-1:0]  set_i,
  output logic                               done_o,
  output srld_pkg::srld_walk_t               walk_o
);

  localparam logic [1:0] GIdle = 2'd0;
  localparam logic [1:0] GScan = 2'd1;
  localparam logic [1:0] GPair = 2'd2;

  localparam int SW = srld_pkg::SensorW;

  logic [1:0]                      state_q, state_d;
  logic [srld_pkg::Sensors-1:0]    set_q, rot_q;
  logic [SW-1:0]                   g_q, best_q, lo_q;
  logic                            done_q;
  srld_pkg::srld_walk_t            walk_q;

  logic                            hit;
  logic [SW-1:0]                   best_d;
  logic [SW:0]                     hi_a, hi_b;
  logic                            va, vb;
  logic [srld_pkg::AngleW-1:0]     ang_a, ang_b;

  assign hit    = |(set_q & rot_q);
  assign best_d = hit ? g_q : best_q;

  assign hi_a  = {1'b0, lo_q} + {1'b0, best_q};
  assign hi_b  = {1'b0, lo_q} + ((SW+1)'(srld_pkg::Sensors) - {1'b0, best_q});
  assign va    = !hi_a[SW] && set_q[hi_a[SW-1:0]];
  assign vb    = (lo_q < best_q) && set_q[hi_b[SW-1:0]];
  assign ang_a = {lo_q, 1'b0} + {1'b0, best_q};
  assign ang_b = {hi_b[SW-1:0], 1'b0} + {1'b0, best_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      GIdle: if (start_i) state_d = GScan;
      GScan: begin
        if (g_q == srld_pkg::HalfRing) begin
          state_d = (best_d == '0) ? GIdle : GPair;
        end
      end
      GPair: if (set_q[lo_q] && (va || vb)) state_d = GIdle;
      default: state_d = GIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == GScan && g_q == srld_pkg::HalfRing && best_d == '0) ||
                 (state_q == GPair && set_q[lo_q] && (va || vb));
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      GIdle: begin
        if (start_i) begin
          set_q  <= set_i;
          rot_q  <= {set_i[0], set_i[srld_pkg::Sensors-1:1]};
          g_q    <= SW'(1);
          best_q <= '0;
        end
      end
      GScan: begin
        best_q <= best_d;
        rot_q  <= {rot_q[0], rot_q[srld_pkg::Sensors-1:1]};
        g_q    <= g_q + SW'(1);
        lo_q   <= '0;
        if (g_q == srld_pkg::HalfRing && best_d == '0) begin
          walk_q.on <= 1'b0;
        end
      end
      GPair: begin
        lo_q <= lo_q + SW'(1);
        if (set_q[lo_q] && (va || vb)) begin
          walk_q.on    <= 1'b1;
          walk_q.angle <= va ? ang_a : ang_b;
          walk_q.chord <= best_q;
          walk_q.lo    <= lo_q;
          walk_q.hi    <= va ? hi_a[SW-1:0] : hi_b[SW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign walk_o = walk_q;

endmodule

`default_nettype wire

>>> hw/rtl/sensor_ring_line_detector.sv
// Sample, threshold load and extremes clear: each request is accepted, then executed.
// Calibrating sample: accept, then max, min and midpoint steps through one shared compare/add unit.
// Frame end: offset scan, then a walk over lower indexes if any pair was found, then the result.
// One request at a time; the result register lets the next request in while it waits.
// Reset (async, active low) clears control, set, held values and extremes valid bits.
// ----------------------------------------------------------------------------
// sensor_ring_line_detector
// Top level: request sequencer, per-sensor storage and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_ring_line_detector (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [srld_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [srld_pkg::ExclW-1:0]        cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire srld_pkg::srld_req_t               in_req_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output srld_pkg::srld_res_t                    out_res_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StMin  = 3'd2;
  localparam logic [2:0] StMid  = 3'd3;
  localparam logic [2:0] StWalk = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  localparam int N  = srld_pkg::Sensors;
  localparam int SB = srld_pkg::SampleBits;

  logic [2:0]                    state_q, state_d;
  srld_pkg::srld_req_t           req_q;
  logic                          cal_q;
  logic [srld_pkg::ExclW-1:0]    excl_q;
  logic [SB-1:0]                 thr_q [N];
  logic [SB-1:0]                 max_q [N];
  logic [SB-1:0]                 min_q [N];
  logic [N-1:0]                  ext_vld_q;
  logic [N-1:0]                  det_q;
  logic                          was_on_q;
  logic [srld_pkg::AngleW-1:0]   held_angle_q;
  logic [srld_pkg::ChordW-1:0]   held_chord_q;
  logic [srld_pkg::SensorW-1:0]  held_lo_q, held_hi_q;
  logic                          out_valid_q;
  srld_pkg::srld_res_t           out_q;

  logic                          accept;
  logic                          load_out;
  logic [SB-1:0]                 max_rd, min_rd, thr_rd;
  logic [SB-1:0]                 alu_a, alu_b, alu_mid;
  logic                          alu_gt;
  logic                          walk_start, walk_done;
  srld_pkg::srld_walk_t          walk;
  srld_pkg::srld_res_t           res_d;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign load_out = (state_q == StOut) && (!out_valid_q || !out_stall_i);

  assign max_rd = ext_vld_q[req_q.sensor] ? max_q[req_q.sensor] : '0;
  assign min_rd = ext_vld_q[req_q.sensor] ? min_q[req_q.sensor] : srld_pkg::MinStart;
  assign thr_rd = thr_q[req_q.sensor];

  always_comb begin
    alu_a = req_q.value;
    alu_b = thr_rd;
    case (state_q)
      StExec: begin
        alu_a = req_q.value;
        alu_b = cal_q ? max_rd : thr_rd;
      end
      StMin: begin
        alu_a = min_rd;
        alu_b = req_q.value;
      end
      StMid: begin
        alu_a = max_rd;
        alu_b = min_rd;
      end
      default: ;
    endcase
  end

  srld_alu u_alu (
    .op_a_i (alu_a),
    .op_b_i (alu_b),
    .gt_o   (alu_gt),
    .mid_o  (alu_mid)
  );

  assign walk_start = (state_q == StExec) && (req_q.kind == srld_pkg::KindFrame);

  srld_gap u_gap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .set_i   (det_q),
    .done_o  (walk_done),
    .walk_o  (walk)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept) state_d = StExec;
      StExec: begin
        case (req_q.kind)
          srld_pkg::KindSample: state_d = cal_q ? StMin : StIdle;
          srld_pkg::KindFrame:  state_d = StWalk;
          default:              state_d = StIdle;
        endcase
      end
      StMin:  state_d = StMid;
      StMid:  state_d = StIdle;
      StWalk: if (walk_done) state_d = StOut;
      StOut:  if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    res_d.on_line       = walk.on;
    res_d.line_angle    = walk.on ? walk.angle : held_angle_q;
    res_d.chord_steps   = walk.on ? walk.chord : held_chord_q;
    res_d.first_contact = walk.on && !was_on_q;
    res_d.gap_start     = walk.on ? walk.lo : held_lo_q;
    res_d.gap_end       = walk.on ? walk.hi : held_hi_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cal_q        <= 1'b0;
      excl_q       <= srld_pkg::ExclW'(N);
      ext_vld_q    <= '0;
      det_q        <= '0;
      was_on_q     <= 1'b0;
      held_angle_q <= '0;
      held_chord_q <= '0;
      held_lo_q    <= '0;
      held_hi_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srld_pkg::CfgCalibrating: cal_q  <= cfg_wdata_i[0];
          srld_pkg::CfgExcluded:    excl_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == StExec) begin
        case (req_q.kind)
          srld_pkg::KindSample: begin
            if (cal_q) begin
              ext_vld_q[req_q.sensor] <= 1'b1;
            end else if (alu_gt && ({1'b0, req_q.sensor} != excl_q)) begin
              det_q[req_q.sensor] <= 1'b1;
            end
          end
          srld_pkg::KindClear: ext_vld_q <= '0;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && !load_out) out_valid_q <= 1'b0;
      if (load_out) begin
        out_valid_q <= 1'b1;
        was_on_q    <= walk.on;
        det_q       <= '0;
        if (walk.on) begin
          held_angle_q <= walk.angle;
          held_chord_q <= walk.chord;
          held_lo_q    <= walk.lo;
          held_hi_q    <= walk.hi;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_req_i;
    if (load_out) out_q <= res_d;
    case (state_q)
      StExec: begin
        if (req_q.kind == srld_pkg::KindThresh) begin
          thr_q[req_q.sensor] <= req_q.value;
        end
        if (req_q.kind == srld_pkg::KindSample && cal_q) begin
          max_q[req_q.sensor] <= alu_gt ? req_q.value : max_rd;
          min_q[req_q.sensor] <= min_rd;
        end
      end
      StMin: if (alu_gt) min_q[req_q.sensor] <= req_q.value;
      StMid: thr_q[req_q.sensor] <= alu_mid;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/srld_chk.sv
// ----------------------------------------------------------------------------
// srld_chk
// Port-level checks of the sensor ring line detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srld_chk (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_o,
  input  wire logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire srld_pkg::srld_res_t  out_res_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result dropped or changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o && !$rose(out_valid_o))
    else $error("request not held busy or result too early");

  a_first_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.first_contact |-> out_res_o.on_line)
    else $error("first contact without on_line");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.on_line |->
      out_res_o.chord_steps != '0 && out_res_o.gap_start < out_res_o.gap_end)
    else $error("bad widest pair");

endmodule

bind sensor_ring_line_detector srld_chk u_srld_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

`default_nettype wire
